[rtl/crr_pkg.sv]
package crr_pkg;

	// Field widths and fixed-point format
	localparam int COORD_WIDTH = 24;
	localparam int T_FRAC_BITS = 15;
	localparam int T_IN_W      = 16;
	localparam int OUT_W       = 28;

	// t clamped to [0, 1.0] needs one integer bit
	localparam int TU_W    = T_FRAC_BITS + 1;
	localparam int T_EXT_W = (T_IN_W > TU_W) ? T_IN_W : TU_W;

	// Weights are bounded by 10 * 1.0 in magnitude
	localparam int W_W    = T_FRAC_BITS + 6;
	localparam int PROD_W = W_W + COORD_WIDTH;
	localparam int ACC_W  = PROD_W + 2;
	localparam int R_W    = ACC_W - T_FRAC_BITS - 1;
	localparam int RX_W   = (R_W > OUT_W) ? R_W : OUT_W + 1;

	localparam int S_DATA_W = ((T_IN_W + 4 * COORD_WIDTH + 7) / 8) * 8;
	localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [TU_W-1:0] T_ONE  = TU_W'(1) << T_FRAC_BITS;
	localparam logic [TU_W-1:0] T_HALF = TU_W'(1) << (T_FRAC_BITS - 1);

	typedef enum logic {
		FN_POS = 1'b0,
		FN_TAN = 1'b1
	} crr_func_t;

	typedef logic signed [COORD_WIDTH-1:0] crr_coord_t;
	typedef logic signed [W_W-1:0]         crr_wt_t;

	typedef struct packed {
		crr_func_t              func;
		logic [T_IN_W-1:0]      t;
		crr_coord_t [3:0]       p;
	} crr_req_t;

	typedef struct packed {
		crr_wt_t [3:0]    w;
		crr_coord_t [3:0] p;
	} crr_item_t;

	typedef struct packed {
		logic full;
		logic avail;
	} crr_q_stat_t;

endpackage

[rtl/crr_front.sv]
module crr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crr_pkg::crr_req_t in_req,
	input  crr_pkg::crr_q_stat_t q_stat,
	output logic              q_push,
	output crr_pkg::crr_item_t q_item
);
	import crr_pkg::*;

	logic adv;

	logic vld_s1, vld_s2, vld_s3;
	crr_func_t func_s1, func_s2;
	crr_coord_t [3:0] p_s1, p_s2;
	logic [TU_W-1:0] tu_s1, tu_s2, s_s2;
	logic [2*TU_W-1:0] sq_s1, cu_s2;
	crr_item_t item_s3;

	logic [T_EXT_W-1:0] t_ext;
	logic [TU_W-1:0] tu_raw, tu;
	logic [2*TU_W-1:0] sq;
	logic [2*TU_W:0] sq_rnd, cu_rnd;
	logic [TU_W-1:0] s_val, c_val;
	crr_wt_t uw, sw, cw, one_w;
	crr_wt_t [3:0] w;

	// Hold the whole front when its last stage cannot drain into the queue
	assign adv      = !vld_s3 || !q_stat.full;
	assign in_ready = adv;
	assign q_push   = vld_s3 && !q_stat.full;
	assign q_item   = item_s3;

	// Stage 1: clamp t, square it
	assign t_ext  = T_EXT_W'(in_req.t);
	assign tu_raw = t_ext[TU_W-1:0];
	assign tu     = (tu_raw > T_ONE) ? T_ONE : tu_raw;
	assign sq     = (2*TU_W)'(tu) * (2*TU_W)'(tu);

	// Stage 2: round t^2, multiply by t
	assign sq_rnd = (2*TU_W+1)'(sq_s1) + (2*TU_W+1)'(T_HALF);
	assign s_val  = sq_rnd[T_FRAC_BITS +: TU_W];

	// Stage 3: round t^3, build basis weights
	assign cu_rnd = (2*TU_W+1)'(cu_s2) + (2*TU_W+1)'(T_HALF);
	assign c_val  = cu_rnd[T_FRAC_BITS +: TU_W];
	assign uw     = W_W'(tu_s2);
	assign sw     = W_W'(s_s2);
	assign cw     = W_W'(c_val);
	assign one_w  = W_W'(T_ONE);

	always_comb begin
		unique case (func_s2)
			FN_POS: begin
				w[0] = crr_wt_t'(sw + sw - cw - uw);
				w[1] = crr_wt_t'(3 * cw - 5 * sw + 2 * one_w);
				w[2] = crr_wt_t'(4 * sw - 3 * cw + uw);
				w[3] = crr_wt_t'(cw - sw);
			end
			FN_TAN: begin
				w[0] = crr_wt_t'(4 * uw - 3 * sw - one_w);
				w[1] = crr_wt_t'(9 * sw - 10 * uw);
				w[2] = crr_wt_t'(8 * uw - 9 * sw + one_w);
				w[3] = crr_wt_t'(3 * sw - 2 * uw);
			end
			default: begin
				w = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1   <= in_req.func;
			p_s1      <= in_req.p;
			tu_s1     <= tu;
			sq_s1     <= sq;
			func_s2   <= func_s1;
			p_s2      <= p_s1;
			tu_s2     <= tu_s1;
			s_s2      <= s_val;
			cu_s2     <= (2*TU_W)'(s_val) * (2*TU_W)'(tu_s1);
			item_s3.w <= w;
			item_s3.p <= p_s2;
		end
	end

	a_t_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (tu_s1 <= T_ONE))
		else $error("clamped t above one");

endmodule

[rtl/crr_fifo.sv]
module crr_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  crr_pkg::crr_item_t   push_item,
	input  logic                 pop,
	output crr_pkg::crr_item_t   pop_item,
	output crr_pkg::crr_q_stat_t stat
);
	import crr_pkg::*;

	crr_item_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic do_push, do_pop;

	function automatic logic [Q_AW-1:0] ptr_next(input logic [Q_AW-1:0] ptr);
		return (ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : ptr + Q_AW'(1);
	endfunction

	assign stat.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.avail = (count_q != '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.avail;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue count past depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

[rtl/crr_back.sv]
module crr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crr_pkg::crr_q_stat_t q_stat,
	input  crr_pkg::crr_item_t   q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [crr_pkg::OUT_W-1:0] out_value,
	output logic                 out_sat
);
	import crr_pkg::*;

	localparam logic signed [RX_W-1:0] SAT_MAX = RX_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [RX_W-1:0] SAT_MIN = RX_W'(-(64'sd1 <<< (OUT_W - 1)));
	localparam logic [OUT_W-1:0] VAL_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] VAL_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	logic adv;
	logic vld_s4, vld_s5, out_vld_q;
	logic signed [PROD_W-1:0] prod_s4 [4];
	logic signed [ACC_W-1:0]  sum01_s5, sum23_s5;
	logic signed [ACC_W-1:0]  acc, accr;
	logic signed [R_W-1:0]    r;
	logic signed [RX_W-1:0]   rx;
	logic [OUT_W-1:0] value_d, value_q;
	logic sat_d, sat_q;

	// Advance the back while the output register is empty or being taken
	assign adv       = !out_vld_q || out_ready;
	assign q_pop     = adv && q_stat.avail;
	assign out_valid = out_vld_q;
	assign out_value = value_q;
	assign out_sat   = sat_q;

	// Round half up, floor shift, clip
	assign acc  = sum01_s5 + sum23_s5;
	assign accr = acc + ACC_W'(T_ONE);
	assign r    = accr[ACC_W-1:T_FRAC_BITS+1];
	assign rx   = RX_W'(r);

	always_comb begin
		priority if (rx > SAT_MAX) begin
			value_d = VAL_MAX;
			sat_d   = 1'b1;
		end else if (rx < SAT_MIN) begin
			value_d = VAL_MIN;
			sat_d   = 1'b1;
		end else begin
			value_d = rx[OUT_W-1:0];
			sat_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s4    <= q_pop;
			vld_s5    <= vld_s4;
			out_vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				prod_s4[i] <= PROD_W'($signed(q_item.w[i])) * PROD_W'($signed(q_item.p[i]));
			end
			sum01_s5 <= ACC_W'(prod_s4[0]) + ACC_W'(prod_s4[1]);
			sum23_s5 <= ACC_W'(prod_s4[2]) + ACC_W'(prod_s4[3]);
			value_q  <= value_d;
			sat_q    <= sat_d;
		end
	end

	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && sat_q) |-> ((value_q == VAL_MAX) || (value_q == VAL_MIN)))
		else $error("saturated result not at a bound");

endmodule

[rtl/catmull_rom_spline_eval_unit.sv]
// Uniform Catmull-Rom spline evaluator, one coordinate axis per request. A request carries
// the segment parameter t (unsigned Q1.15, values above 1.0 clamp to 1.0), four signed Q16.8
// control coordinates p0..p3, and a mode on s_tuser: 0 returns the position between p1 and p2,
// 1 returns the tangent dP/dt. The result is a signed Q20.8 coordinate, rounded half up and
// clipped to 28 bits; m_tuser flags a clipped result. Evaluate a 3-D point with three requests,
// one per axis. The unit accepts one request per clock while s_tready is high and returns
// results in request order. A request passes through three front stages (t squared, t cubed,
// basis weights), a four-entry queue, and three back stages (four weight-by-coordinate
// multiplies, pair sums, final sum with rounding and clipping into the output register).
// The queue lets the front keep accepting while the output side stalls; s_tready drops only
// once the queue is full and the last front stage holds a request.
module catmull_rom_spline_eval_unit (
	input  logic clk,
	input  logic arst_n,

	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [crr_pkg::S_DATA_W-1:0]  s_tdata,  // t[15:0], p0, p1, p2, p3 (24 bits each)
	input  logic                          s_tuser,  // func: 0 position, 1 tangent

	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [crr_pkg::M_DATA_W-1:0]  m_tdata,  // value[27:0], zero fill above
	output logic                          m_tuser   // saturated
);
	import crr_pkg::*;

	crr_req_t    req;
	crr_item_t   fr_item, q_item;
	crr_q_stat_t q_stat;
	logic        q_push, q_pop;
	logic [OUT_W-1:0] value;
	logic        sat;

	// Unpack the request fields from the stream words
	always_comb begin
		req.func = crr_func_t'(s_tuser);
		req.t    = s_tdata[T_IN_W-1:0];
		for (int i = 0; i < 4; i++) begin
			req.p[i] = s_tdata[T_IN_W + i*COORD_WIDTH +: COORD_WIDTH];
		end
	end

	crr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_req   (req),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_item   (fr_item)
	);

	crr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (fr_item),
		.pop       (q_pop),
		.pop_item  (q_item),
		.stat      (q_stat)
	);

	crr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (value),
		.out_sat   (sat)
	);

	// Pack the result; upper bits of the data word stay zero
	assign m_tdata = M_DATA_W'(value);
	assign m_tuser = sat;

endmodule

[tb/sv/catmull_rom_spline_eval_unit_tb.sv]
module catmull_rom_spline_eval_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crr_pkg::*;

	// Extremes of a control coordinate
	localparam crr_coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam crr_coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Run shape: about 1650 requests in all, sent as three-axis vectors
	localparam int N_VECTORS   = 544;
	localparam int PAUSE_AT    = 250;   // vector index where the sender drains the unit
	localparam int HOLD_AT     = 200;   // accepted requests before the long output stall
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             sat;
	} coord_result_t;

	// One row of the corner table; typed rows carry their expected value
	typedef struct {
		crr_func_t         fn;
		logic [T_IN_W-1:0] t;
		crr_coord_t        p0, p1, p2, p3;
		bit                typed;
		int                val;
	} req_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 m_tuser;

	coord_result_t expected_coords[$];
	int            err_count = 0;
	int            req_count = 0;
	int            rx_hold_left = 0;
	bit            tx_calm = 1'b0;

	catmull_rom_spline_eval_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Spline coordinate: clamp t to 1.0, build t^2 and t^3 rounded half up, form the
	// basis weights scaled by 2.0, take the exact dot product with p0..p3, then round
	// half up to Q20.8 and clip to the output range.
	function automatic coord_result_t spline_coord(crr_func_t fn, logic [T_IN_W-1:0] t,
			crr_coord_t p0, crr_coord_t p1, crr_coord_t p2, crr_coord_t p3);
		longint one, half, tu, sq, cu, w0, w1, w2, w3, acc, r, hi, lo;
		coord_result_t res;
		one  = longint'(1) << T_FRAC_BITS;
		half = longint'(1) << (T_FRAC_BITS - 1);
		hi   = (longint'(1) << (OUT_W - 1)) - 1;
		lo   = -(longint'(1) << (OUT_W - 1));
		// drop t bits above the Q1.F range, then clamp anything above 1.0
		tu = longint'(t) & ((longint'(1) << TU_W) - 1);
		if (tu > one)
			tu = one;
		sq = (tu * tu + half) >>> T_FRAC_BITS;
		cu = (sq * tu + half) >>> T_FRAC_BITS;
		if (fn == FN_POS) begin
			w0 = -cu + 2 * sq - tu;
			w1 = 3 * cu - 5 * sq + 2 * one;
			w2 = -3 * cu + 4 * sq + tu;
			w3 = cu - sq;
		end else begin
			w0 = -3 * sq + 4 * tu - one;
			w1 = 9 * sq - 10 * tu;
			w2 = -9 * sq + 8 * tu + one;
			w3 = 3 * sq - 2 * tu;
		end
		acc = w0 * longint'(p0) + w1 * longint'(p1) + w2 * longint'(p2) + w3 * longint'(p3);
		// arithmetic shift of a signed longint is a floor division
		r = (acc + one) >>> (T_FRAC_BITS + 1);
		res.sat = 1'b0;
		if (r > hi) begin
			r = hi;
			res.sat = 1'b1;
		end else if (r < lo) begin
			r = lo;
			res.sat = 1'b1;
		end
		res.value = OUT_W'(r);
		return res;
	endfunction

	// Gap length for either side: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Control coordinate: full random mostly, with extremes and small values mixed in
	function automatic crr_coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return CMAX;
			1: return CMIN;
			2, 3: return crr_coord_t'($signed($urandom_range(0, 2047)) - 1024);
			default: return crr_coord_t'($urandom());
		endcase
	endfunction

	// Segment parameter: mostly in [0, 1.0], sometimes exactly on the ends,
	// sometimes above 1.0 to exercise the clamp
	function automatic logic [T_IN_W-1:0] rand_t();
		case ($urandom_range(0, 9))
			7: return $urandom_range(0, 1) ? T_IN_W'(T_ONE) : '0;
			8: return T_IN_W'($urandom_range(int'(T_ONE) + 1, (1 << T_IN_W) - 1));
			9: return T_IN_W'($urandom());
			default: return T_IN_W'($urandom_range(0, int'(T_ONE)));
		endcase
	endfunction

	// Offer one request; hold it until accepted, then log what the output must carry.
	// Enter and leave just after a falling edge.
	task automatic offer_request(input req_row_t row);
		int gap;
		if ($urandom_range(0, 149) == 0)
			tx_calm = !tx_calm;
		// keep offering while the output side is held off so the unit backs up
		gap = (tx_calm || rx_hold_left > 0) ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= row.fn;
		s_tdata  <= S_DATA_W'({row.p3, row.p2, row.p1, row.p0, row.t});
		do
			@(posedge clk);
		while (!s_tready);
		req_count++;
		if (row.typed)
			expected_coords.push_back('{value: OUT_W'(row.val), sat: 1'b0});
		else
			expected_coords.push_back(spline_coord(row.fn, row.t, row.p0, row.p1, row.p2, row.p3));
		@(negedge clk);
	endtask

	// Stimulus: reset, corner table, then random three-axis vectors
	initial begin
		req_row_t   corner_rows[$];
		req_row_t   row;
		crr_func_t  fn;
		logic [T_IN_W-1:0] tv;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;

		// Position at t = 0 is p1 and at t >= 1.0 is p2; tangent at t = 0 is
		// (p2 - p0) / 2 and at t = 1.0 is (p3 - p1) / 2, both rounded half up.
		corner_rows = '{
			'{FN_POS, 16'd0,     100,  1280, -300,  7,     1'b1, 1280},
			'{FN_POS, 16'd32768, 100,  1280, -300,  7,     1'b1, -300},
			'{FN_POS, 16'hFFFF,  -5,   9,    4242,  1,     1'b1, 4242},
			'{FN_POS, 16'd32769, 1,    2,    3,     4,     1'b1, 3},
			'{FN_POS, 16'hAAAA,  24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
				1'b1, int'(crr_coord_t'(24'h555555))},
			'{FN_TAN, 16'd0,     0,    77,   2000,  -9,    1'b1, 1000},
			'{FN_TAN, 16'd32768, 55,   0,    12,    -4000, 1'b1, -2000},
			'{FN_TAN, 16'hFFFF,  55,   0,    12,    -4000, 1'b1, -2000},
			'{FN_POS, 16'd0,     CMIN, CMAX, CMIN,  CMIN,  1'b1, int'(CMAX)},
			'{FN_POS, 16'd0,     CMAX, CMIN, CMAX,  CMAX,  1'b1, int'(CMIN)},
			'{FN_POS, 16'd32768, CMAX, CMIN, CMAX,  CMIN,  1'b1, int'(CMAX)},
			'{FN_POS, 16'd32768, CMIN, CMAX, CMIN,  CMAX,  1'b1, int'(CMIN)},
			'{FN_TAN, 16'd0,     CMIN, 0,    CMAX,  0,     1'b1, 8388608},
			'{FN_TAN, 16'd32768, 0,    CMAX, 0,     CMIN,  1'b1, -8388607},
			// worst-case weight and sign mixes, checked against the predictor
			'{FN_POS, 16'd16384, CMAX, CMAX, CMAX,  CMAX,  1'b0, 0},
			'{FN_POS, 16'd16384, CMIN, CMAX, CMAX,  CMIN,  1'b0, 0},
			'{FN_POS, 16'd16384, CMAX, CMIN, CMIN,  CMAX,  1'b0, 0},
			'{FN_TAN, 16'd16384, CMAX, CMIN, CMAX,  CMIN,  1'b0, 0},
			'{FN_TAN, 16'd8192,  CMAX, CMIN, CMAX,  CMIN,  1'b0, 0},
			'{FN_TAN, 16'd24576, CMIN, CMAX, CMIN,  CMAX,  1'b0, 0},
			'{FN_POS, 16'd1,     -1,   -1,   -1,    -1,    1'b0, 0},
			'{FN_TAN, 16'd32767, 24'h123456, 24'hFEDCBA, 24'h0F0F0F, 24'hF0F0F0, 1'b0, 0},
			'{FN_POS, 16'd12345, CMIN, CMIN, CMIN,  CMIN,  1'b0, 0},
			'{FN_TAN, 16'd20000, CMIN, CMIN, CMIN,  CMIN,  1'b0, 0}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (corner_rows[i])
			offer_request(corner_rows[i]);

		for (int v = 0; v < N_VECTORS; v++) begin
			// once mid-run, stop offering until the unit has emptied out
			if (v == PAUSE_AT) begin
				s_tvalid <= 1'b0;
				while (expected_coords.size() != 0)
					@(posedge clk);
				@(negedge clk);
			end
			fn = crr_func_t'($urandom_range(0, 1));
			tv = rand_t();
			for (int ax = 0; ax < 3; ax++) begin
				// most vectors share t across axes; some redraw it per axis
				if ($urandom_range(0, 4) == 0)
					tv = rand_t();
				row = '{fn, tv, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0, 0};
				offer_request(row);
			end
		end
		s_tvalid <= 1'b0;

		// drain, then give late or extra results time to show up
		while (expected_coords.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Output side: random stalls, calm stretches, and one long hold-off counted here
	initial begin
		int  stall_left;
		bit  rx_calm;
		bit  hold_done;
		stall_left = 0;
		rx_calm    = 1'b0;
		hold_done  = 1'b0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0)
				rx_calm = !rx_calm;
			if (!hold_done && req_count >= HOLD_AT) begin
				hold_done    = 1'b1;
				rx_hold_left = HOLD_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Check every accepted result against the oldest pending expectation
	always @(posedge clk) begin
		coord_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_coords.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual value %0d sat %0b",
					$time, $signed(m_tdata[OUT_W-1:0]), m_tuser);
				err_count++;
			end else begin
				want = expected_coords.pop_front();
				if (m_tdata !== M_DATA_W'(want.value)) begin
					$display("%0t: value mismatch, expected %0d (%h), actual %0d (%h)",
						$time, $signed(want.value), M_DATA_W'(want.value),
						$signed(m_tdata[OUT_W-1:0]), m_tdata);
					err_count++;
				end
				if (m_tuser !== want.sat) begin
					$display("%0t: saturated flag mismatch, expected %0b, actual %0b",
						$time, want.sat, m_tuser);
					err_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
rtl/crr_pkg.sv
rtl/crr_front.sv
rtl/crr_fifo.sv
rtl/crr_back.sv
rtl/catmull_rom_spline_eval_unit.sv
tb/sv/catmull_rom_spline_eval_unit_tb.sv
